/* hw/rtl/snmpv1_trap_ber_parser_top_macros.svh */
// Assertion helpers shared by the trap parser modules.
// Each macro expects clk and arst_n in scope.
`ifndef SNMPV1_TRAP_BER_PARSER_TOP_MACROS_SVH
`define SNMPV1_TRAP_BER_PARSER_TOP_MACROS_SVH

// Condition holds at every edge outside reset.
`define TRAPBER_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TRAPBER_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/trapber_pkg.sv */
// ----------------------------------------------------------------------------
// trapber_pkg
// Types, codes and decode tables of the SNMPv1 trap BER parser.
// ----------------------------------------------------------------------------
package trapber_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int LEN_BYTES   = (LENGTH_BITS + 7) / 8;
	localparam int LCNT_W      = $clog2(LEN_BYTES + 1);
	localparam int MAX_RES     = 3;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

	typedef enum logic [3:0] {
		PH_OUTER      = 4'd0,
		PH_VERSION    = 4'd1,
		PH_COMMUNITY  = 4'd2,
		PH_PDU        = 4'd3,
		PH_ENTERPRISE = 4'd4,
		PH_AGENT      = 4'd5,
		PH_GENERIC    = 4'd6,
		PH_SPECIFIC   = 4'd7,
		PH_TIME       = 4'd8,
		PH_VBLIST     = 4'd9,
		PH_VB         = 4'd10,
		PH_VBNAME     = 4'd11,
		PH_VBVALUE    = 4'd12,
		PH_HALT       = 4'd13
	} phase_t;

	typedef enum logic [1:0] {
		ST_TAG  = 2'd0,
		ST_LEN  = 2'd1,
		ST_LENX = 2'd2,
		ST_VAL  = 2'd3
	} stage_t;

	typedef enum logic [2:0] {
		CL_BAD  = 3'd0,
		CL_INT  = 3'd1,
		CL_U32  = 3'd2,
		CL_U64  = 3'd3,
		CL_OCT  = 3'd4,
		CL_NULL = 3'd5,
		CL_OID  = 3'd6
	} cls_t;

	typedef enum logic [3:0] {
		K_COMMUNITY  = 4'd0,
		K_ENTERPRISE = 4'd1,
		K_AGENT      = 4'd2,
		K_GENERIC    = 4'd3,
		K_SPECIFIC   = 4'd4,
		K_TIME       = 4'd5,
		K_NAME       = 4'd6,
		K_INT        = 4'd7,
		K_UNSIGNED   = 4'd8,
		K_OCTET      = 4'd9,
		K_NULL       = 4'd10,
		K_DONE       = 4'd11
	} kind_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_BAD_TAG   = 3'd1,
		STS_OVERRUN   = 3'd2,
		STS_TOO_LONG  = 3'd3,
		STS_BAD_VER   = 3'd4,
		STS_TRUNCATED = 3'd5,
		STS_BAD_OID   = 3'd6,
		STS_BAD_LEN   = 3'd7
	} status_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic        first;
		logic [2:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_RES-1:0]     res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic cls_t tag_class(input logic [7:0] tag);
		case (tag)
			8'h02: return CL_INT;
			8'h41, 8'h42, 8'h43, 8'h47: return CL_U32;
			8'h46: return CL_U64;
			8'h03, 8'h04, 8'h40, 8'h44: return CL_OCT;
			8'h05: return CL_NULL;
			8'h06: return CL_OID;
			default: return CL_BAD;
		endcase
	endfunction

	function automatic logic [7:0] want_tag(input phase_t p);
		case (p)
			PH_OUTER:      return 8'h30;
			PH_VERSION:    return 8'h02;
			PH_COMMUNITY:  return 8'h04;
			PH_PDU:        return 8'hA4;
			PH_ENTERPRISE: return 8'h06;
			PH_AGENT:      return 8'h40;
			PH_GENERIC:    return 8'h02;
			PH_SPECIFIC:   return 8'h02;
			PH_TIME:       return 8'h43;
			PH_VBLIST:     return 8'h30;
			PH_VB:         return 8'h30;
			PH_VBNAME:     return 8'h06;
			default:       return 8'h00;
		endcase
	endfunction

	function automatic phase_t next_phase(input phase_t p);
		case (p)
			PH_OUTER:      return PH_VERSION;
			PH_VERSION:    return PH_COMMUNITY;
			PH_COMMUNITY:  return PH_PDU;
			PH_PDU:        return PH_ENTERPRISE;
			PH_ENTERPRISE: return PH_AGENT;
			PH_AGENT:      return PH_GENERIC;
			PH_GENERIC:    return PH_SPECIFIC;
			PH_SPECIFIC:   return PH_TIME;
			PH_TIME:       return PH_VBLIST;
			PH_VBLIST:     return PH_VB;
			PH_VB:         return PH_VBNAME;
			PH_VBNAME:     return PH_VBVALUE;
			PH_VBVALUE:    return PH_VB;
			default:       return PH_HALT;
		endcase
	endfunction

	// Append one result; a full bundle drops it.
	function automatic bundle_t push_res(input bundle_t bd, input logic [3:0] k,
			input logic [63:0] v, input logic f, input logic [2:0] s, input logic l);
		bundle_t r;
		r = bd;
		if (r.cnt != 2'(MAX_RES)) begin
			r.res[r.cnt].kind   = k;
			r.res[r.cnt].value  = v;
			r.res[r.cnt].first  = f;
			r.res[r.cnt].status = s;
			r.res[r.cnt].last   = l;
			r.cnt = r.cnt + 2'd1;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/snmpv1_trap_ber_parser_top.sv */
// ----------------------------------------------------------------------------
// snmpv1_trap_ber_parser_top
// SNMPv1 trap message decoder: walks the BER structure one byte per item and
// emits community, OID arcs, address octets, trap code, timestamp and values.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_byte, last_byte
// out       output     out_valid / out_stall kind, value, first_of_field,
//                                            status, last_of_message
// cfg       input      cfg_valid / cfg_ready cfg_data (max_value_len)
//
// Bytes enter one per cycle unless in_stall; each yields zero to three results.
// Results leave one per cycle unless out_stall, so output paces dense runs.
// A four-bundle queue decouples parser and output; in_stall rises when it fills.
// Reset leaves max_value_len at 1024 and the parser waiting for a new message.
// ----------------------------------------------------------------------------
module snmpv1_trap_ber_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [63:0] value,
	output logic        first_of_field,
	output logic [2:0]  status,
	output logic        last_of_message,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import trapber_pkg::*;

	logic    push;
	logic    pop;
	bundle_t push_data;
	bundle_t head;
	qstat_t  qstat;

	assign cfg_ready = 1'b1;

	trapber_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	trapber_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	trapber_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.qstat           (qstat),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.value           (value),
		.first_of_field  (first_of_field),
		.status          (status),
		.last_of_message (last_of_message)
	);

endmodule

/* hw/rtl/trapber_front.sv */
// ----------------------------------------------------------------------------
// trapber_front
// Byte-level BER walker: checks tags and lengths, decodes values and packs
// the results caused by one byte into a bundle for the queue.
// ----------------------------------------------------------------------------
module trapber_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 last_byte,
	input  logic                 cfg_valid,
	input  logic [15:0]          cfg_data,
	input  trapber_pkg::qstat_t  qstat,
	output logic                 push,
	output trapber_pkg::bundle_t push_data
);
	import trapber_pkg::*;

	phase_t      phase_q, nxt_phase;
	stage_t      stage_q, nxt_stage;
	logic [7:0]  tag_q, nxt_tag;
	logic [LCNT_W-1:0] lleft_q, nxt_lleft;
	logic [31:0] vleft_q, nxt_vleft;
	logic [3:0]  bidx_q, nxt_bidx;
	logic [63:0] acc_q, nxt_acc;
	logic [31:0] arc_q, nxt_arc;
	logic [31:0] gen_q, nxt_gen;
	logic [2:0]  err_q, nxt_err;
	logic [63:0] pos_q, nxt_pos;
	logic [63:0] need_q, nxt_need;
	logic        oidf_q, nxt_oidf;
	logic [15:0] max_len_q;
	bundle_t     bd;
	logic        take;

	assign in_stall = qstat.full;
	assign take     = in_valid && !in_stall;

	always_comb begin
		logic        do_len;
		logic        do_leaf;
		logic        vbad;
		logic        lbad;
		logic        ok;
		logic [31:0] len;
		logic [63:0] acc_n;
		logic [63:0] end_v;
		logic [6:0]  cnt;
		cls_t        cls;
		logic [3:0]  kd;
		logic [31:0] arc_n;
		logic [1:0]  hi;
		logic [31:0] lo;
		logic [31:0] gen_p1;
		logic [2:0]  fin;
		logic [63:0] pos_n;

		nxt_phase = phase_q;
		nxt_stage = stage_q;
		nxt_tag   = tag_q;
		nxt_lleft = lleft_q;
		nxt_vleft = vleft_q;
		nxt_bidx  = bidx_q;
		nxt_acc   = acc_q;
		nxt_arc   = arc_q;
		nxt_gen   = gen_q;
		nxt_err   = err_q;
		nxt_need  = need_q;
		nxt_oidf  = oidf_q;
		bd        = '0;
		do_len    = 1'b0;
		do_leaf   = 1'b0;
		vbad      = 1'b0;
		lbad      = 1'b0;
		ok        = 1'b0;
		len       = '0;
		acc_n     = '0;
		end_v     = '0;
		cnt       = in_byte[6:0];
		cls       = tag_class(tag_q);
		kd        = K_NAME;
		arc_n     = '0;
		hi        = '0;
		lo        = '0;
		gen_p1    = '0;
		fin       = STS_OK;
		pos_n     = pos_q + 64'd1;
		nxt_pos   = pos_n;

		if (phase_q != PH_HALT) begin
			case (stage_q)
				ST_TAG: begin
					nxt_tag = in_byte;
					if (phase_q == PH_VBVALUE)
						ok = (tag_class(in_byte) != CL_BAD);
					else
						ok = (in_byte == want_tag(phase_q));
					if (ok) begin
						nxt_stage = ST_LEN;
					end else begin
						if (nxt_err == STS_OK) nxt_err = STS_BAD_TAG;
						nxt_phase = PH_HALT;
					end
				end
				ST_LEN: begin
					if (!in_byte[7]) begin
						do_len = 1'b1;
						len    = {24'd0, in_byte};
					end else if (cnt == 7'd0 || cnt > 7'(LEN_BYTES)) begin
						if (nxt_err == STS_OK) nxt_err = STS_BAD_LEN;
						nxt_phase = PH_HALT;
					end else begin
						nxt_acc   = '0;
						nxt_lleft = LCNT_W'(cnt);
						nxt_stage = ST_LENX;
					end
				end
				ST_LENX: begin
					acc_n   = {acc_q[55:0], in_byte};
					nxt_acc = acc_n;
					if (acc_n[63:LENGTH_BITS] != '0) begin
						if (nxt_err == STS_OK) nxt_err = STS_BAD_LEN;
						nxt_phase = PH_HALT;
					end else begin
						if (lleft_q != '0) nxt_lleft = lleft_q - 1'b1;
						if (nxt_lleft == '0) begin
							do_len = 1'b1;
							len    = acc_n[31:0];
						end
					end
				end
				default: begin
					case (cls)
						CL_INT: begin
							if (bidx_q < 4'd4)
								nxt_acc = (bidx_q == 4'd0) ? {{56{in_byte[7]}}, in_byte}
									: {acc_q[55:0], in_byte};
						end
						CL_U32: begin
							if (bidx_q < 4'd4) nxt_acc = {acc_q[55:0], in_byte};
						end
						CL_U64: begin
							if (bidx_q < 4'd8) nxt_acc = {acc_q[55:0], in_byte};
						end
						CL_OCT: begin
							kd = (phase_q == PH_COMMUNITY) ? K_COMMUNITY
								: (phase_q == PH_AGENT) ? K_AGENT : K_OCTET;
							bd = push_res(bd, kd, {56'd0, in_byte}, bidx_q == 4'd0,
								STS_OK, 1'b0);
						end
						CL_OID: begin
							if ((arc_q == '0 && in_byte == 8'h80) || arc_q[31:25] != '0) begin
								if (nxt_err == STS_OK) nxt_err = STS_BAD_OID;
								nxt_phase = PH_HALT;
								vbad      = 1'b1;
							end else begin
								arc_n   = {arc_q[24:0], in_byte[6:0]};
								nxt_arc = arc_n;
								kd = (phase_q == PH_ENTERPRISE) ? K_ENTERPRISE : K_NAME;
								if (!in_byte[7]) begin
									if (oidf_q) begin
										// split the first subidentifier by 40
										hi = (arc_n < 32'd40) ? 2'd0 : (arc_n < 32'd80) ? 2'd1 : 2'd2;
										lo = arc_n - ((hi == 2'd0) ? 32'd0
											: (hi == 2'd1) ? 32'd40 : 32'd80);
										bd = push_res(bd, kd, {62'd0, hi}, 1'b1, STS_OK, 1'b0);
										bd = push_res(bd, kd, {32'd0, lo}, 1'b0, STS_OK, 1'b0);
										nxt_oidf = 1'b0;
									end else begin
										bd = push_res(bd, kd, {32'd0, arc_n}, 1'b0, STS_OK, 1'b0);
									end
									nxt_arc = '0;
								end
							end
						end
						default: ;
					endcase
					if (!vbad) begin
						if (bidx_q < 4'd15) nxt_bidx = bidx_q + 4'd1;
						if (vleft_q != '0) nxt_vleft = vleft_q - 32'd1;
						if (nxt_vleft == '0) do_leaf = 1'b1;
					end
				end
			endcase
		end

		if (do_len) begin
			end_v = pos_n + {32'd0, len};
			if (end_v > need_q) nxt_need = end_v;
			if (tag_q == 8'h30 || tag_q == 8'hA4) begin
				nxt_phase = next_phase(phase_q);
				nxt_stage = ST_TAG;
			end else if (len > {16'd0, max_len_q}) begin
				if (nxt_err == STS_OK) nxt_err = STS_TOO_LONG;
				nxt_phase = PH_HALT;
			end else if (cls == CL_INT && len == '0) begin
				if (nxt_err == STS_OK) nxt_err = STS_BAD_LEN;
				nxt_phase = PH_HALT;
			end else begin
				nxt_vleft = len;
				nxt_bidx  = '0;
				nxt_acc   = '0;
				nxt_arc   = '0;
				nxt_oidf  = 1'b1;
				if (len == '0) do_leaf = 1'b1;
				else nxt_stage = ST_VAL;
			end
		end

		if (do_leaf) begin
			if (cls == CL_OID && (nxt_arc != '0 || nxt_oidf)) begin
				if (nxt_err == STS_OK) nxt_err = STS_BAD_OID;
				nxt_phase = PH_HALT;
				lbad      = 1'b1;
			end else begin
				gen_p1 = nxt_acc[31:0] + 32'd1;
				case (phase_q)
					PH_VERSION: begin
						if (nxt_acc != '0) begin
							if (nxt_err == STS_OK) nxt_err = STS_BAD_VER;
							nxt_phase = PH_HALT;
							lbad      = 1'b1;
						end
					end
					PH_GENERIC: begin
						nxt_gen = nxt_acc[31:0];
						if (nxt_acc[31:0] != 32'd6)
							bd = push_res(bd, K_GENERIC, {32'd0, gen_p1}, 1'b1, STS_OK, 1'b0);
					end
					PH_SPECIFIC: begin
						if (gen_q == 32'd6)
							bd = push_res(bd, K_SPECIFIC, {32'd0, nxt_acc[31:0]}, 1'b1,
								STS_OK, 1'b0);
					end
					PH_TIME: bd = push_res(bd, K_TIME, nxt_acc, 1'b1, STS_OK, 1'b0);
					PH_VBVALUE: begin
						if (cls == CL_INT)
							bd = push_res(bd, K_INT, nxt_acc, 1'b1, STS_OK, 1'b0);
						else if (cls == CL_U32 || cls == CL_U64)
							bd = push_res(bd, K_UNSIGNED, nxt_acc, 1'b1, STS_OK, 1'b0);
						else if (cls == CL_NULL)
							bd = push_res(bd, K_NULL, 64'd0, 1'b1, STS_OK, 1'b0);
					end
					default: ;
				endcase
				if (!lbad) begin
					nxt_phase = next_phase(phase_q);
					nxt_stage = ST_TAG;
				end
			end
		end

		if (last_byte) begin
			fin = nxt_err;
			if (fin == STS_OK) begin
				// an overrun shows only against the final position
				if (pos_n < need_q || (do_len && len != '0))
					fin = STS_OVERRUN;
				else if (!(nxt_phase == PH_VB && nxt_stage == ST_TAG))
					fin = STS_TRUNCATED;
			end
			bd = push_res(bd, K_DONE, 64'd0, 1'b0, fin, 1'b1);
			nxt_phase = PH_OUTER;
			nxt_stage = ST_TAG;
			nxt_tag   = '0;
			nxt_lleft = '0;
			nxt_vleft = '0;
			nxt_bidx  = '0;
			nxt_acc   = '0;
			nxt_arc   = '0;
			nxt_gen   = '0;
			nxt_err   = STS_OK;
			nxt_pos   = '0;
			nxt_need  = '0;
			nxt_oidf  = 1'b1;
		end
	end

	assign push      = take && (bd.cnt != 2'd0);
	assign push_data = bd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OUTER;
			stage_q   <= ST_TAG;
			tag_q     <= '0;
			lleft_q   <= '0;
			vleft_q   <= '0;
			bidx_q    <= '0;
			acc_q     <= '0;
			arc_q     <= '0;
			gen_q     <= '0;
			err_q     <= STS_OK;
			pos_q     <= '0;
			need_q    <= '0;
			oidf_q    <= 1'b1;
		end else if (take) begin
			phase_q   <= nxt_phase;
			stage_q   <= nxt_stage;
			tag_q     <= nxt_tag;
			lleft_q   <= nxt_lleft;
			vleft_q   <= nxt_vleft;
			bidx_q    <= nxt_bidx;
			acc_q     <= nxt_acc;
			arc_q     <= nxt_arc;
			gen_q     <= nxt_gen;
			err_q     <= nxt_err;
			pos_q     <= nxt_pos;
			need_q    <= nxt_need;
			oidf_q    <= nxt_oidf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

endmodule

/* hw/rtl/trapber_queue.sv */
// ----------------------------------------------------------------------------
// trapber_queue
// Short FIFO of result bundles between the parser and the output side.
// ----------------------------------------------------------------------------
module trapber_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  trapber_pkg::bundle_t push_data,
	input  logic                 pop,
	output trapber_pkg::bundle_t head,
	output trapber_pkg::qstat_t  qstat
);
	import trapber_pkg::*;

	bundle_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`include "snmpv1_trap_ber_parser_top_macros.svh"

	`TRAPBER_CHECK(a_no_push_full, !(push && qstat.full), "push into full queue")
	`TRAPBER_CHECK(a_no_pop_empty, !(pop && qstat.empty), "pop from empty queue")
	`TRAPBER_CHECK(a_cnt_range, cnt_q <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

/* hw/rtl/trapber_back.sv */
// ----------------------------------------------------------------------------
// trapber_back
// Output side: holds one bundle, emits one result per cycle unless out_stall.
// ----------------------------------------------------------------------------
module trapber_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trapber_pkg::bundle_t head,
	input  trapber_pkg::qstat_t  qstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           kind,
	output logic [63:0]          value,
	output logic                 first_of_field,
	output logic [2:0]           status,
	output logic                 last_of_message
);
	import trapber_pkg::*;

	bundle_t    hold_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       take;
	logic       done_cur;
	result_t    cur;

	assign take     = valid_q && !out_stall;
	assign done_cur = take && (idx_q + 2'd1 == hold_q.cnt);
	assign pop      = !qstat.empty && (!valid_q || done_cur);
	assign cur      = hold_q.res[idx_q];

	assign out_valid       = valid_q;
	assign kind            = cur.kind;
	assign value           = cur.value;
	assign first_of_field  = cur.first;
	assign status          = cur.status;
	assign last_of_message = cur.last;

	always_ff @(posedge clk) begin
		if (pop) hold_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done_cur) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

`include "snmpv1_trap_ber_parser_top_macros.svh"

	`TRAPBER_CHECK(a_hold_nonempty, !valid_q || hold_q.cnt != 2'd0, "empty bundle held")
	`TRAPBER_CHECK(a_idx_in_range, !valid_q || idx_q < hold_q.cnt, "index past bundle")
	`TRAPBER_CHECK_NEXT(a_stall_holds, valid_q && out_stall, valid_q && $stable(idx_q), "stalled result moved")

endmodule
